>>> design/brme_pkg.sv
// shared constants, operation codes and types for the byte register machine execute block
`default_nettype none

package brme_pkg;

    localparam int DATA_W    = 8;
    localparam int FUNC_W    = 4;
    localparam int RIDX_W    = 4;
    localparam int OPB_W     = 8;

    localparam int REG_COUNT = 16;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int MEM_BYTES = 256;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    // iteration counter of the divider, holds the full step count
    localparam int DIV_CW    = $clog2(DATA_W + 1);

    localparam logic [FUNC_W-1:0] F_NOP   = 4'd0;
    localparam logic [FUNC_W-1:0] F_ADD   = 4'd1;
    localparam logic [FUNC_W-1:0] F_SUB   = 4'd2;
    localparam logic [FUNC_W-1:0] F_MUL   = 4'd3;
    localparam logic [FUNC_W-1:0] F_DIV   = 4'd4;
    localparam logic [FUNC_W-1:0] F_MOV   = 4'd5;
    localparam logic [FUNC_W-1:0] F_LOAD  = 4'd6;
    localparam logic [FUNC_W-1:0] F_STORE = 4'd7;
    localparam logic [FUNC_W-1:0] F_SET   = 4'd8;
    localparam logic [FUNC_W-1:0] F_PRINT = 4'd9;
    localparam logic [FUNC_W-1:0] F_DEBUG = 4'd10;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

endpackage

`default_nettype wire

>>> design/brme_if.sv
// request channel interfaces for instructions in and print results out
`default_nettype none

interface brme_in_if;
    logic                         valid;
    logic                         ready;
    logic [brme_pkg::FUNC_W-1:0]  func;
    logic [brme_pkg::RIDX_W-1:0]  op_a;
    logic [brme_pkg::OPB_W-1:0]   op_b;
    logic [brme_pkg::RIDX_W-1:0]  op_c;

    modport source (output valid, output func, output op_a, output op_b, output op_c,
                    input ready);
    modport sink   (input valid, input func, input op_a, input op_b, input op_c,
                    output ready);
endinterface

interface brme_out_if;
    logic                         valid;
    logic                         ready;
    logic                         shown;
    logic                         channel;
    logic [brme_pkg::RIDX_W-1:0]  shown_index;
    logic [brme_pkg::DATA_W-1:0]  shown_value;
    logic                         divide_by_zero;

    modport source (output valid, output shown, output channel, output shown_index,
                    output shown_value, output divide_by_zero, input ready);
    modport sink   (input valid, input shown, input channel, input shown_index,
                    input shown_value, input divide_by_zero, output ready);
endinterface

`default_nettype wire

>>> design/brme_div.sv
// iterative restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module brme_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire brme_pkg::t_div_req            i_req,
    output logic                               o_busy,
    output logic [brme_pkg::DATA_W-1:0]        o_quot
);
    import brme_pkg::*;

    logic                r_busy;
    logic [DIV_CW-1:0]   r_cnt;
    logic [DATA_W-1:0]   r_rem;
    logic [DATA_W-1:0]   r_quot;
    logic [DATA_W-1:0]   r_dvs;

    logic [DATA_W:0]     rem_sh;
    logic [DATA_W:0]     dvs_ext;
    logic [DATA_W:0]     diff;
    logic                ge;

    always_comb begin
        rem_sh  = {r_rem, r_quot[DATA_W-1]};
        dvs_ext = {1'b0, r_dvs};
        ge      = (rem_sh >= dvs_ext);
        diff    = rem_sh - dvs_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CW'(DATA_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quot <= i_req.dividend;
            r_dvs  <= i_req.divisor;
        end else if (r_busy) begin
            // remainder after a subtract stays below the divisor
            r_rem  <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            r_quot <= {r_quot[DATA_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

>>> design/byte_register_machine_execute.sv
// top level: byte register machine execute stage with register file and data memory
//
// usage
//   i_in carries one fetched instruction per request (func, op_a, op_b, op_c);
//   o_out returns exactly one result per instruction, in order: print flags,
//   printed register index and value, and the divide-by-zero flag
//   instructions are taken one at a time; i_in.ready is high while the block idles
// steps, from the accepting edge to the next possible accept
//   nop, alu ops, move, set, store, print, debug: register file read, execute
//   load: register file read, execute, then an extra data memory read step
//   divide: register file read, divider start, bit-serial divider steps, commit
//   divide by zero skips the divider and commits in its execute step
//   a result appears on o_out in the cycle after its final step
// reset
//   after i_rst_n is released the block sweeps the data memory and the register
//   file to zero, one entry a cycle, over all MEM_BYTES (256) addresses; no
//   request is taken during the sweep
// back-pressure
//   the result sits in an output register; the next instruction is taken while it
//   waits, and that instruction holds in its final step until the slot frees
`default_nettype none

module byte_register_machine_execute (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    brme_in_if.sink    i_in,
    brme_out_if.source o_out
);
    import brme_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_LOAD  = 5'b01000,
        S_DIV   = 5'b10000
    } t_state;

    // control state
    t_state               r_state, n_state;
    logic [MEM_AW-1:0]    r_clr, n_clr;
    logic                 r_out_valid;

    // latched instruction
    logic [FUNC_W-1:0]    r_func;
    logic [REG_AW-1:0]    r_ia, r_ib, r_ic;
    logic [OPB_W-1:0]     r_imm;

    // registered read data of both memories
    logic [DATA_W-1:0]    r_a, r_b;
    logic [DATA_W-1:0]    r_mem_q;

    // memories
    logic [DATA_W-1:0]    r_rf_mem [REG_COUNT];
    logic [DATA_W-1:0]    r_dm_mem [MEM_BYTES];

    // output register
    logic                 r_shown, r_channel, r_dz;
    logic [RIDX_W-1:0]    r_sidx;
    logic [DATA_W-1:0]    r_sval;

    // combinational controls
    logic                 accept;
    logic                 slot_free;
    logic                 commit;
    logic                 rf_we;
    logic [REG_AW-1:0]    rf_wa;
    logic [DATA_W-1:0]    rf_wd;
    logic                 dm_we;
    logic [MEM_AW-1:0]    dm_wa;
    logic [DATA_W-1:0]    dm_wd;
    logic                 dm_re;
    logic                 res_shown, res_channel, res_dz;
    logic [2*DATA_W-1:0]  prod;
    t_div_req             div_req;
    logic                 div_busy;
    logic [DATA_W-1:0]    div_quot;

    localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(MEM_BYTES - 1);

    assign accept    = i_in.valid && i_in.ready;
    assign slot_free = !r_out_valid || o_out.ready;
    assign prod      = r_a * r_b;

    brme_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state          = r_state;
        n_clr            = r_clr;
        commit           = 1'b0;
        rf_we            = 1'b0;
        rf_wa            = r_ic;
        rf_wd            = '0;
        dm_we            = 1'b0;
        dm_wa            = r_a[MEM_AW-1:0];
        dm_wd            = r_b;
        dm_re            = 1'b0;
        res_shown        = 1'b0;
        res_channel      = 1'b0;
        res_dz           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_a;
        div_req.divisor  = r_b;

        unique case (r_state)
            S_CLEAR: begin
                // zero both memories, register file by the low index bits
                rf_we = 1'b1;
                rf_wa = r_clr[REG_AW-1:0];
                dm_we = 1'b1;
                dm_wa = r_clr;
                dm_wd = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_func == F_LOAD) begin
                    dm_re   = 1'b1;
                    n_state = S_LOAD;
                end else if (r_func == F_DIV && r_b != '0) begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV;
                end else if (slot_free) begin
                    commit  = 1'b1;
                    n_state = S_IDLE;
                    unique case (r_func) inside
                        F_ADD: begin
                            rf_we = 1'b1;
                            rf_wd = r_a + r_b;
                        end
                        F_SUB: begin
                            rf_we = 1'b1;
                            rf_wd = r_a - r_b;
                        end
                        F_MUL: begin
                            rf_we = 1'b1;
                            rf_wd = prod[DATA_W-1:0];
                        end
                        F_DIV: begin
                            // zero divisor, destination untouched
                            res_dz = 1'b1;
                        end
                        F_MOV: begin
                            rf_we = 1'b1;
                            rf_wa = r_ib;
                            rf_wd = r_a;
                        end
                        F_STORE: begin
                            dm_we = 1'b1;
                        end
                        F_SET: begin
                            rf_we = 1'b1;
                            rf_wa = r_ia;
                            rf_wd = r_imm[DATA_W-1:0];
                        end
                        F_PRINT, F_DEBUG: begin
                            res_shown   = 1'b1;
                            res_channel = (r_func == F_DEBUG);
                        end
                        default: begin
                            // nop and unused codes change nothing
                        end
                    endcase
                end
            end
            S_LOAD: begin
                if (slot_free) begin
                    commit  = 1'b1;
                    rf_we   = 1'b1;
                    rf_wa   = r_ib;
                    rf_wd   = r_mem_q;
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (!div_busy && slot_free) begin
                    commit  = 1'b1;
                    rf_we   = 1'b1;
                    rf_wd   = div_quot;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // instruction latch, register indexes reduced to the file size
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_in.func;
            r_ia   <= i_in.op_a[REG_AW-1:0];
            r_ib   <= i_in.op_b[REG_AW-1:0];
            r_ic   <= i_in.op_c[REG_AW-1:0];
            r_imm  <= i_in.op_b;
        end
    end

    // register file: one write port, two registered read ports
    // reads happen only at accept, writes only in other states, so no overlap
    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf_mem[rf_wa] <= rf_wd;
        end
        if (accept) begin
            r_a <= r_rf_mem[i_in.op_a[REG_AW-1:0]];
            r_b <= r_rf_mem[i_in.op_b[REG_AW-1:0]];
        end
    end

    // data memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            r_dm_mem[dm_wa] <= dm_wd;
        end
        if (dm_re) begin
            r_mem_q <= r_dm_mem[r_a[MEM_AW-1:0]];
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_shown   <= res_shown;
            r_channel <= res_channel;
            r_sidx    <= res_shown ? RIDX_W'(r_ia) : '0;
            r_sval    <= res_shown ? r_a : '0;
            r_dz      <= res_dz;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.shown          = r_shown;
    assign o_out.channel        = r_channel;
    assign o_out.shown_index    = r_sidx;
    assign o_out.shown_value    = r_sval;
    assign o_out.divide_by_zero = r_dz;

endmodule

`default_nettype wire
